/* hw/rtl/jan_pkg.sv */
// ----------------------------------------------------------------------------
// jan_pkg
// Shared types and constants for the joystick auto-ranging normalizer.
// ----------------------------------------------------------------------------
package jan_pkg;

    // Sample and register widths
    localparam int SAMPLE_BITS = 12;
    localparam int NZ_BITS     = 12;
    localparam int AXIS_BITS   = 16;

    // Signed threshold width: center +/- null zone plus headroom for differences
    localparam int THR_BITS = ((SAMPLE_BITS > NZ_BITS) ? SAMPLE_BITS : NZ_BITS) + 3;

    // Divider: one quotient bit per step, Q1.15 needs AXIS_BITS bits
    localparam int QUO_STEPS = AXIS_BITS;
    localparam int CNT_BITS  = $clog2(QUO_STEPS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(QUO_STEPS - 1);

    localparam logic [NZ_BITS-1:0]   NULL_ZONE_RESET = NZ_BITS'(128);
    localparam logic [AXIS_BITS-1:0] AXIS_MAX = {1'b0, {(AXIS_BITS-1){1'b1}}};

    // Calibration phase
    typedef enum logic [2:0] {
        PH_CAPTURE = 3'd0,
        PH_WAIT1   = 3'd1,
        PH_RANGING = 3'd2,
        PH_WAIT2   = 3'd3,
        PH_RUNNING = 3'd4
    } phase_t;

    // Per-item sequencer
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_UPDATE,
        SEQ_START,
        SEQ_DIV,
        SEQ_DONE
    } seq_t;

    // Controller to datapath commands
    typedef struct packed {
        logic in_load;
        logic capture;
        logic track;
        logic div_start;
        logic div_step;
        logic out_load;
        logic axes_en;
        logic calibrated;
    } jan_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic pressed;
        logic spans_ok;
        logic out_free;
    } jan_stat_t;

endpackage

/* hw/rtl/jan_div.sv */
// ----------------------------------------------------------------------------
// jan_div
// One axis lane: dead-zone thresholds and a restoring divider producing
// the Q1.15 axis value one quotient bit per step.
// ----------------------------------------------------------------------------
module jan_div
    import jan_pkg::*;
(
    input  logic                        clk,
    input  logic                        start,
    input  logic                        step,
    input  logic [SAMPLE_BITS-1:0]      center,
    input  logic [SAMPLE_BITS-1:0]      low,
    input  logic [SAMPLE_BITS-1:0]      high,
    input  logic [SAMPLE_BITS-1:0]      sample,
    input  logic [NZ_BITS-1:0]          null_zone,
    output logic [AXIS_BITS-1:0]        result
);

    localparam int SW = SAMPLE_BITS;

    logic signed [THR_BITS-1:0] c_s, nz_s, n_s, hi_s, lo_s;
    logic signed [THR_BITS-1:0] tp, tn, pos_den, neg_den, pos_num, neg_num;
    logic [SW-1:0]              num, den;
    logic                       neg, zero;

    logic [SW:0]                rem_reg, rem_next;
    logic [SW-1:0]              den_reg;
    logic [AXIS_BITS-1:0]       quo_reg, quo_next;
    logic                       neg_reg, zero_reg;
    logic                       ge;
    logic [SW:0]                diff;

    // Thresholds and operand selection
    always_comb
    begin
        c_s  = $signed({{(THR_BITS-SW){1'b0}}, center});
        n_s  = $signed({{(THR_BITS-SW){1'b0}}, sample});
        hi_s = $signed({{(THR_BITS-SW){1'b0}}, high});
        lo_s = $signed({{(THR_BITS-SW){1'b0}}, low});
        nz_s = $signed({{(THR_BITS-NZ_BITS){1'b0}}, null_zone});
        tp   = c_s + nz_s;
        tn   = c_s - nz_s;
        pos_den = hi_s - tp;
        neg_den = tn - lo_s;
        pos_num = n_s - tp;
        neg_num = tn - n_s;

        num  = '0;
        den  = '0;
        neg  = 1'b0;
        zero = 1'b1;
        if (n_s > tp)
        begin
            if (!pos_den[THR_BITS-1] && (pos_den != '0))
            begin
                num  = pos_num[SW-1:0];
                den  = pos_den[SW-1:0];
                zero = 1'b0;
            end
        end
        else if (n_s < tn)
        begin
            if (!neg_den[THR_BITS-1] && (neg_den != '0))
            begin
                num  = neg_num[SW-1:0];
                den  = neg_den[SW-1:0];
                neg  = 1'b1;
                zero = 1'b0;
            end
        end
    end

    // Restoring step: compare, subtract, shift
    always_comb
    begin
        ge       = (rem_reg >= {1'b0, den_reg});
        diff     = ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next = {diff[SW-1:0], 1'b0};
        quo_next = {quo_reg[AXIS_BITS-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quo_reg  <= '0;
            neg_reg  <= neg;
            zero_reg <= zero;
        end
        else if (step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    // Sign and saturation: quotient never exceeds 1.0
    always_comb
    begin
        if (zero_reg)
            result = '0;
        else if (neg_reg)
            result = '0 - quo_reg;
        else if (quo_reg[AXIS_BITS-1])
            result = AXIS_MAX;
        else
            result = quo_reg;
    end

endmodule

/* hw/rtl/jan_dp.sv */
// ----------------------------------------------------------------------------
// jan_dp
// Datapath: null zone register, sample capture, calibration registers,
// span test, two divider lanes and the output register.
// ----------------------------------------------------------------------------
module jan_dp
    import jan_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  jan_cmd_t                    cmd,
    output jan_stat_t                   stat,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [NZ_BITS-1:0]          cfg_data,
    input  logic [SAMPLE_BITS-1:0]      x_sample,
    input  logic [SAMPLE_BITS-1:0]      y_sample,
    input  logic                        button_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [AXIS_BITS-1:0] speed,
    output logic signed [AXIS_BITS-1:0] steer,
    output logic                        button_pressed,
    output logic                        calibrated
);

    logic [NZ_BITS-1:0]     nz_reg;
    logic [SAMPLE_BITS-1:0] xs_reg, ys_reg;
    logic                   pressed_reg;
    logic [SAMPLE_BITS-1:0] x_center_reg, x_low_reg, x_high_reg;
    logic [SAMPLE_BITS-1:0] y_center_reg, y_low_reg, y_high_reg;
    logic [AXIS_BITS-1:0]   x_result, y_result;
    logic                   out_valid_reg;
    logic [AXIS_BITS-1:0]   speed_reg, steer_reg;
    logic                   pressed_out_reg, calibrated_reg;

    // Does the range reach the null-zone edge on both sides of center
    function automatic logic spans(
        input logic [SAMPLE_BITS-1:0] c,
        input logic [SAMPLE_BITS-1:0] lo,
        input logic [SAMPLE_BITS-1:0] hi,
        input logic [NZ_BITS-1:0]     nz
    );
        logic signed [THR_BITS-1:0] c_s, nz_s, lo_s, hi_s;
        c_s  = $signed({{(THR_BITS-SAMPLE_BITS){1'b0}}, c});
        lo_s = $signed({{(THR_BITS-SAMPLE_BITS){1'b0}}, lo});
        hi_s = $signed({{(THR_BITS-SAMPLE_BITS){1'b0}}, hi});
        nz_s = $signed({{(THR_BITS-NZ_BITS){1'b0}}, nz});
        return (lo_s <= (c_s - nz_s)) && (hi_s >= (c_s + nz_s));
    endfunction

    // Configuration register, always writable
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nz_reg <= NULL_ZONE_RESET;
        else if (cfg_valid && cfg_ready)
            nz_reg <= cfg_data;
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            xs_reg      <= x_sample;
            ys_reg      <= y_sample;
            pressed_reg <= ~button_level;
        end
    end

    // Center, low and high per axis
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_center_reg <= '0;
            x_low_reg    <= '0;
            x_high_reg   <= '0;
            y_center_reg <= '0;
            y_low_reg    <= '0;
            y_high_reg   <= '0;
        end
        else if (cmd.capture)
        begin
            x_center_reg <= xs_reg;
            x_low_reg    <= xs_reg;
            x_high_reg   <= xs_reg;
            y_center_reg <= ys_reg;
            y_low_reg    <= ys_reg;
            y_high_reg   <= ys_reg;
        end
        else if (cmd.track)
        begin
            if (x_low_reg > xs_reg)
                x_low_reg <= xs_reg;
            else if (x_high_reg < xs_reg)
                x_high_reg <= xs_reg;
            if (y_low_reg > ys_reg)
                y_low_reg <= ys_reg;
            else if (y_high_reg < ys_reg)
                y_high_reg <= ys_reg;
        end
    end

    // Axis lanes
    jan_div u_div_x (
        .clk       (clk),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .center    (x_center_reg),
        .low       (x_low_reg),
        .high      (x_high_reg),
        .sample    (xs_reg),
        .null_zone (nz_reg),
        .result    (x_result)
    );

    jan_div u_div_y (
        .clk       (clk),
        .start     (cmd.div_start),
        .step      (cmd.div_step),
        .center    (y_center_reg),
        .low       (y_low_reg),
        .high      (y_high_reg),
        .sample    (ys_reg),
        .null_zone (nz_reg),
        .result    (y_result)
    );

    // Output register: holds one result until its transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            speed_reg       <= cmd.axes_en ? x_result : '0;
            steer_reg       <= cmd.axes_en ? y_result : '0;
            pressed_out_reg <= pressed_reg;
            calibrated_reg  <= cmd.calibrated;
        end
    end

    assign out_valid      = out_valid_reg;
    assign speed          = $signed(speed_reg);
    assign steer          = $signed(steer_reg);
    assign button_pressed = pressed_out_reg;
    assign calibrated     = calibrated_reg;

    // Status
    assign stat.pressed  = pressed_reg;
    assign stat.spans_ok = spans(x_center_reg, x_low_reg, x_high_reg, nz_reg) &&
                           spans(y_center_reg, y_low_reg, y_high_reg, nz_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

/* hw/rtl/jan_ctrl.sv */
// ----------------------------------------------------------------------------
// jan_ctrl
// Controller: calibration phase tracking and the per-item sequencer that
// drives capture, range tracking, division and result loading.
// ----------------------------------------------------------------------------
module jan_ctrl
    import jan_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  jan_stat_t stat,
    output jan_cmd_t  cmd
);

    seq_t                state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic                norm_reg, norm_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;

    // Phase decision for the item under update
    logic   act_capture, act_track, act_norm;
    phase_t phase_after;

    always_comb
    begin
        act_capture = 1'b0;
        act_track   = 1'b0;
        act_norm    = 1'b0;
        phase_after = phase_reg;
        unique case (phase_reg)
            PH_WAIT1:
            begin
                if (!stat.pressed)
                    phase_after = PH_RANGING;
            end
            PH_RANGING:
            begin
                if (stat.pressed && stat.spans_ok)
                    phase_after = PH_WAIT2;
                else
                    act_track = 1'b1;
            end
            PH_WAIT2:
            begin
                if (!stat.pressed)
                    phase_after = PH_RUNNING;
            end
            PH_RUNNING:
            begin
                act_track = 1'b1;
                act_norm  = 1'b1;
            end
            default:
            begin
                // capture, and any unused code
                act_capture = 1'b1;
                phase_after = stat.pressed ? PH_WAIT1 : PH_RANGING;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        norm_next  = norm_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (in_valid)
                    state_next = SEQ_UPDATE;
            end
            SEQ_UPDATE:
            begin
                phase_next = phase_after;
                norm_next  = act_norm;
                state_next = act_norm ? SEQ_START : SEQ_DONE;
            end
            SEQ_START:
            begin
                cnt_next   = '0;
                state_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = SEQ_DONE;
            end
            SEQ_DONE:
            begin
                if (stat.out_free)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd            = '0;
        in_ready       = 1'b0;
        cmd.axes_en    = norm_reg;
        cmd.calibrated = (phase_reg == PH_RUNNING);
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
            end
            SEQ_UPDATE:
            begin
                cmd.capture = act_capture;
                cmd.track   = act_track;
            end
            SEQ_START:
            begin
                cmd.div_start = 1'b1;
            end
            SEQ_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            SEQ_DONE:
            begin
                cmd.out_load = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            phase_reg <= PH_CAPTURE;
            norm_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            norm_reg  <= norm_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hw/rtl/joystick_autorange_normalizer_core.sv */
// ----------------------------------------------------------------------------
// joystick_autorange_normalizer_core
// Two-axis joystick normalizer: captures center, auto-ranges low and high,
// then maps each axis with a dead zone to Q1.15.
//
// Channel   Signals                                      Direction
// input     in_valid/in_ready, x_sample, y_sample,       in
//           button_level
// result    out_valid/out_ready, speed, steer,           out
//           button_pressed, calibrated
// config    cfg_valid/cfg_ready, cfg_data (null zone)    in
//
// An item is taken only while the sequencer is idle. Outside the running
// phase an item passes the update and done states; in running it also passes
// the start state and the 16-step restoring divider (one per axis, in parallel).
// Reset (rst_n, asynchronous) clears the phase and calibration and sets the null zone to 128.
// One result waits in the output register while the next item is taken; a
// further result holds in the controller until that register frees.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module joystick_autorange_normalizer_core
    import jan_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [SAMPLE_BITS-1:0]      x_sample,
    input  logic [SAMPLE_BITS-1:0]      y_sample,
    input  logic                        button_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [AXIS_BITS-1:0] speed,
    output logic signed [AXIS_BITS-1:0] steer,
    output logic                        button_pressed,
    output logic                        calibrated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [NZ_BITS-1:0]          cfg_data
);

    jan_cmd_t  cmd;
    jan_stat_t stat;

    // Sequencer and phase control
    jan_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath
    jan_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .x_sample       (x_sample),
        .y_sample       (y_sample),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speed          (speed),
        .steer          (steer),
        .button_pressed (button_pressed),
        .calibrated     (calibrated)
    );

endmodule

/* tb/joystick_autorange_normalizer_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_autorange_normalizer_core_tb
// Self-checking bench for the joystick normalizer. A short stimulus table
// walks the calibration sequence once: center capture, both release waits,
// auto-ranging with and without a passing span test, and the running phase
// at null zones of 128 and 0. Random sample pairs then drive the running
// phase under several null-zone settings and stall patterns. Each result
// transfer is checked against the table's expected values or an in-bench
// model of the calibration and dead-zone scaling.
// ----------------------------------------------------------------------------
module joystick_autorange_normalizer_core_tb;
    import jan_pkg::*;

    localparam int SAMPLE_MAX = (1 << SAMPLE_BITS) - 1;

    // Expected result of one input transfer
    typedef struct packed {
        logic signed [AXIS_BITS-1:0] speed;
        logic signed [AXIS_BITS-1:0] steer;
        logic                        pressed;
        logic                        cal;
    } axes_result_t;

    // Stimulus table rows: a sample pair or a null-zone write
    typedef enum logic {
        ROW_ITEM,
        ROW_NZ
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic                   lvl;
        logic [NZ_BITS-1:0]     nz;
        bit                     typed;
        axes_result_t           res;
    } dir_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [SAMPLE_BITS-1:0]      x_sample;
    logic [SAMPLE_BITS-1:0]      y_sample;
    logic                        button_level;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [AXIS_BITS-1:0] speed;
    logic signed [AXIS_BITS-1:0] steer;
    logic                        button_pressed;
    logic                        calibrated;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [NZ_BITS-1:0]          cfg_data;

    // Model of calibration state and register
    phase_t                 cal_phase;
    logic [NZ_BITS-1:0]     nz_model;
    logic [SAMPLE_BITS-1:0] x_ctr, x_lo, x_hi;
    logic [SAMPLE_BITS-1:0] y_ctr, y_lo, y_hi;

    axes_result_t pending_axes[$];
    dir_row_t     dir_rows[$];

    int err_count = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_cal     = 0;
    int n_full    = 0;
    int n_cfg     = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int rx_hold_len   = 0;

    joystick_autorange_normalizer_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .x_sample       (x_sample),
        .y_sample       (y_sample),
        .button_level   (button_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .speed          (speed),
        .steer          (steer),
        .button_pressed (button_pressed),
        .calibrated     (calibrated),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(5_000_000);
        $display("joystick_autorange_normalizer_core_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model
    // ------------------------------------------------------------------------

    // Min/max tracking: a new low wins over a new high
    function automatic void widen_range(input logic [SAMPLE_BITS-1:0] s,
                                        inout logic [SAMPLE_BITS-1:0] lo,
                                        inout logic [SAMPLE_BITS-1:0] hi);
        if (lo > s)
            lo = s;
        else if (hi < s)
            hi = s;
    endfunction

    // Range reaches the dead-band edge on both sides (signed thresholds)
    function automatic bit covers_dead_band(logic [SAMPLE_BITS-1:0] c,
                                            logic [SAMPLE_BITS-1:0] lo,
                                            logic [SAMPLE_BITS-1:0] hi);
        return (int'(lo) <= int'(c) - int'(nz_model)) &&
               (int'(hi) >= int'(c) + int'(nz_model));
    endfunction

    // Dead-zone scaling to Q1.15, truncated toward zero
    function automatic int scale_axis(int lo, int c, int hi, int now);
        int     tp;
        int     tn;
        int     den;
        longint q;
        tp = c + int'(nz_model);
        tn = c - int'(nz_model);
        if (now > tp)
        begin
            den = hi - tp;
            if (den <= 0)
                return 0;
            q = (longint'(now - tp) * 32768) / den;
            return (q > 32767) ? 32767 : int'(q);
        end
        if (now < tn)
        begin
            den = tn - lo;
            if (den <= 0)
                return 0;
            q = (longint'(tn - now) * 32768) / den;
            if (q > 32768)
                q = 32768;
            return -int'(q);
        end
        return 0;
    endfunction

    // One sample pair through the calibration phases
    function automatic axes_result_t step_normalizer(input logic [SAMPLE_BITS-1:0] xs,
                                                     input logic [SAMPLE_BITS-1:0] ys,
                                                     input logic lvl);
        axes_result_t r;
        logic         pr;
        pr = ~lvl;
        r  = '0;
        case (cal_phase)
            PH_WAIT1:
                if (!pr)
                    cal_phase = PH_RANGING;
            PH_RANGING:
                if (pr && covers_dead_band(x_ctr, x_lo, x_hi) &&
                    covers_dead_band(y_ctr, y_lo, y_hi))
                    cal_phase = PH_WAIT2;
                else
                begin
                    widen_range(xs, x_lo, x_hi);
                    widen_range(ys, y_lo, y_hi);
                end
            PH_WAIT2:
                if (!pr)
                    cal_phase = PH_RUNNING;
            PH_RUNNING:
            begin
                widen_range(xs, x_lo, x_hi);
                widen_range(ys, y_lo, y_hi);
                r.speed = AXIS_BITS'(scale_axis(int'(x_lo), int'(x_ctr), int'(x_hi),
                                                int'(xs)));
                r.steer = AXIS_BITS'(scale_axis(int'(y_lo), int'(y_ctr), int'(y_hi),
                                                int'(ys)));
            end
            // capture, and any stray code
            default:
            begin
                x_ctr     = xs;
                x_lo      = xs;
                x_hi      = xs;
                y_ctr     = ys;
                y_lo      = ys;
                y_hi      = ys;
                cal_phase = pr ? PH_WAIT1 : PH_RANGING;
            end
        endcase
        r.pressed = pr;
        r.cal     = (cal_phase == PH_RUNNING);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus table helpers
    // ------------------------------------------------------------------------
    function automatic void row_item(int x, int y, bit lvl);
        dir_row_t row;
        row       = '{kind: ROW_ITEM, default: '0};
        row.x     = SAMPLE_BITS'(x);
        row.y     = SAMPLE_BITS'(y);
        row.lvl   = lvl;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_item_exp(int x, int y, bit lvl, int sp, int st,
                                         bit pr, bit cal);
        dir_row_t row;
        row             = '{kind: ROW_ITEM, default: '0};
        row.x           = SAMPLE_BITS'(x);
        row.y           = SAMPLE_BITS'(y);
        row.lvl         = lvl;
        row.typed       = 1'b1;
        row.res.speed   = AXIS_BITS'(sp);
        row.res.steer   = AXIS_BITS'(st);
        row.res.pressed = pr;
        row.res.cal     = cal;
        dir_rows.push_back(row);
    endfunction

    function automatic void row_nz(int v);
        dir_row_t row;
        row      = '{kind: ROW_NZ, default: '0};
        row.nz   = NZ_BITS'(v);
        dir_rows.push_back(row);
    endfunction

    // Random sample: mostly near center, some near thresholds and rails
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(logic [SAMPLE_BITS-1:0] ctr);
        int sel;
        int v;
        int c;
        c   = int'(ctr);
        sel = $urandom_range(99);
        if (sel < 40)
            v = c + int'($urandom_range(600)) - 300;
        else if (sel < 60)
            v = c + int'($urandom_range(2000)) - 1000;
        else if (sel < 75)
            v = int'($urandom_range(SAMPLE_MAX));
        else if (sel < 90)
            v = c + ($urandom_range(1) ? int'(nz_model) : -int'(nz_model)) +
                int'($urandom_range(2)) - 1;
        else
            v = $urandom_range(1) ? SAMPLE_MAX : 0;
        if (v < 0)
            v = 0;
        if (v > SAMPLE_MAX)
            v = SAMPLE_MAX;
        return SAMPLE_BITS'(v);
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks (called at a rising edge, return at the transfer edge)
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [SAMPLE_BITS-1:0] xs,
                             input logic [SAMPLE_BITS-1:0] ys,
                             input logic lvl, input bit typed,
                             input axes_result_t want);
        int           gap;
        axes_result_t pred;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        x_sample     <= xs;
        y_sample     <= ys;
        button_level <= lvl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pred = step_normalizer(xs, ys, lvl);
        pending_axes.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_axes.size() != 0)
            @(posedge clk);
    endtask

    // Register writes only with the block drained
    task automatic write_null_zone(input logic [NZ_BITS-1:0] v);
        wait_all_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        nz_model = v;
        n_cfg++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------------
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                out_ready <= 1'b0;
                repeat (rx_hold_len) @(posedge clk);
                rx_hold_len = 0;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        axes_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            n_results++;
            if (calibrated)
                n_cal++;
            if (int'(speed) == 32767 || int'(speed) == -32768 ||
                int'(steer) == 32767 || int'(steer) == -32768)
                n_full++;
            if (pending_axes.size() == 0)
            begin
                $display("%0t: unexpected result transfer: expected none, got speed %0d steer %0d",
                         $time, speed, steer);
                err_count++;
            end
            else
            begin
                want = pending_axes.pop_front();
                check_field("speed", int'(want.speed), int'(speed));
                check_field("steer", int'(want.steer), int'(steer));
                check_field("button_pressed", int'(want.pressed), int'(button_pressed));
                check_field("calibrated", int'(want.cal), int'(calibrated));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        axes_result_t none_res;
        logic [NZ_BITS-1:0] nz_next;
        int count;

        none_res     = '0;
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        x_sample     <= '0;
        y_sample     <= '0;
        button_level <= 1'b1;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;

        cal_phase = PH_CAPTURE;
        nz_model  = NULL_ZONE_RESET;
        x_ctr = '0; x_lo = '0; x_hi = '0;
        y_ctr = '0; y_lo = '0; y_hi = '0;

        // Calibration walk, center 2048 on both axes, reset null zone 128
        row_item_exp(2048, 2048, 0, 0, 0, 1, 0);   // capture while pressed
        row_item_exp(0, 4095, 0, 0, 0, 1, 0);      // still pressed: ignored
        row_item_exp(2048, 2048, 1, 0, 0, 0, 0);   // release: on to ranging
        row_item_exp(1921, 2175, 1, 0, 0, 0, 0);
        row_item_exp(2175, 1921, 1, 0, 0, 0, 0);
        row_item_exp(2176, 2176, 0, 0, 0, 1, 0);   // press, one count short
        row_item_exp(1920, 1920, 0, 0, 0, 1, 0);   // press, still short on both lows
        row_nz(4095);                              // threshold past full scale
        row_item_exp(1800, 2300, 0, 0, 0, 1, 0);   // press can never end ranging
        row_nz(128);
        row_item_exp(2300, 1800, 1, 0, 0, 0, 0);
        row_item_exp(0, 0, 0, 0, 0, 1, 0);         // press ends ranging, not tracked
        row_item_exp(4095, 4095, 0, 0, 0, 1, 0);   // second wait ignores it
        row_item_exp(2048, 2048, 1, 0, 0, 0, 1);   // release: running
        row_item(2176, 1920, 1);                   // right on both thresholds
        row_item(2177, 1919, 1);                   // one count outside
        row_item_exp(2300, 1800, 0, 32767, -32768, 1, 1);
        row_item_exp(0, 4095, 1, -32768, 32767, 0, 1);
        row_item_exp(2500, 1500, 0, 32767, -32768, 1, 1);
        row_item(2200, 1700, 1);
        row_nz(0);
        row_item(2049, 2047, 0);
        row_item(2048, 2048, 1);
        row_item(1000, 3000, 1);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 31;
        recv_idle_pct = 50;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_NZ)
                write_null_zone(dir_rows[i].nz);
            else
                send_item(dir_rows[i].x, dir_rows[i].y, dir_rows[i].lvl,
                          dir_rows[i].typed, dir_rows[i].res);
        end

        // Random running-phase traffic in segments
        for (int seg = 0; seg < 6; seg++)
        begin
            case (seg)
                0: begin nz_next = NZ_BITS'(64);                   count = 150; end
                1: begin nz_next = NZ_BITS'($urandom_range(400));  count = 150; end
                2: begin nz_next = NZ_BITS'(SAMPLE_MAX);           count = 40;  end
                3: begin nz_next = NZ_BITS'(300);                  count = 150; end
                4: begin nz_next = NZ_BITS'(200);                  count = 150; end
                default: begin nz_next = NULL_ZONE_RESET;          count = 150; end
            endcase
            send_idle_pct = (seg < 2) ? 31 : (seg < 4) ? 50 : 0;
            recv_idle_pct = (seg < 2) ? 50 : (seg < 4) ? 31 : 0;
            write_null_zone(nz_next);
            for (int k = 0; k < count; k++)
            begin
                // long receiver hold-off so the block backs up its input
                if (seg == 3 && k == 20)
                    rx_hold_len = 300;
                // sender pause until everything in flight has come out
                if (seg == 4 && k == 75)
                    wait_all_results();
                send_item(pick_sample(x_ctr), pick_sample(y_ctr),
                          ($urandom_range(99) < 70), 1'b0, none_res);
            end
        end

        wait_all_results();
        repeat (40) @(posedge clk);

        $display("run covered %0d sample transfers and %0d result transfers, %0d calibrated",
                 n_items, n_results, n_cal);
        $display("%0d results hit full scale; %0d null-zone writes incl. 0 and 4095; phase %s",
                 n_full, n_cfg, cal_phase.name());
        if (err_count == 0)
            $display("joystick_autorange_normalizer_core_tb: clean");
        else
            $display("joystick_autorange_normalizer_core_tb: errors");
        $finish;
    end

endmodule

/* joystick_autorange_normalizer_core.f */
hw/rtl/jan_pkg.sv
hw/rtl/jan_div.sv
hw/rtl/jan_dp.sv
hw/rtl/jan_ctrl.sv
hw/rtl/joystick_autorange_normalizer_core.sv
tb/joystick_autorange_normalizer_core_tb.sv
